/* rtl/core/xyc_ivk_pkg.sv */
package xyc_ivk_pkg;

   // fixed-point format of all rate, length and angle fields
   localparam int FRAC_BITS = 16;

   // default CORDIC depth and the length of the arctangent table
   localparam int TRIG_ITERATIONS_DEF = 16;
   localparam int ATAN_LEN            = 24;

   // field widths
   localparam int LEN_W   = 32;
   localparam int ANG_W   = 26;
   localparam int ARM_W   = 31;
   localparam int DIFF_W  = ANG_W + 1;   // tcp angle minus tool angle
   localparam int RATE_W  = 28;          // angle rate in rad/s, Q(F)
   localparam int TURN_W  = 32;          // binary angle, 2^32 per turn
   localparam int TRIG_W  = 32;          // sin/cos in Q2.30

   // register map
   typedef enum logic [1:0] {
      REG_ARM_LENGTH    = 2'd0,
      REG_TOOL_OFFSET_X = 2'd1,
      REG_TOOL_OFFSET_Y = 2'd2,
      REG_TOOL_ANGLE    = 2'd3
   } reg_index_type;

   localparam logic [ARM_W-1:0] ARM_RESET = ARM_W'(650 << FRAC_BITS);

   // pi/180 in Q0.32
   localparam logic signed [RATE_W-1:0] DEG_TO_RAD = RATE_W'(74961321);

   // values that travel alongside the angle path
   typedef struct packed {
      logic signed [LEN_W-1:0]  x_rate;
      logic signed [LEN_W-1:0]  y_rate;
      logic signed [LEN_W-1:0]  angle_rate;
      logic signed [RATE_W-1:0] w;
   } side_type;

   // arctangent of 2^-i in binary angle units
   function automatic logic [TURN_W-1:0] atan_turn(input int idx);
      logic [TURN_W-1:0] v;
      case (idx)
         0:  v = 32'h20000000;
         1:  v = 32'h12E4051E;
         2:  v = 32'h09FB385B;
         3:  v = 32'h051111D4;
         4:  v = 32'h028B0D43;
         5:  v = 32'h0145D7E1;
         6:  v = 32'h00A2F61E;
         7:  v = 32'h00517C55;
         8:  v = 32'h0028BE53;
         9:  v = 32'h00145F2F;
         10: v = 32'h000A2F98;
         11: v = 32'h000517CC;
         12: v = 32'h00028BE6;
         13: v = 32'h000145F3;
         14: v = 32'h0000A2F9;
         15: v = 32'h0000517C;
         16: v = 32'h000028BE;
         17: v = 32'h0000145F;
         18: v = 32'h00000A2F;
         19: v = 32'h00000517;
         20: v = 32'h0000028B;
         21: v = 32'h00000145;
         22: v = 32'h000000A2;
         23: v = 32'h00000051;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

/* rtl/core/xyc_ivk_angle.sv */
module xyc_ivk_angle (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_vld,
   input  logic signed [xyc_ivk_pkg::DIFF_W-1:0]      in_angle,
   input  xyc_ivk_pkg::side_type                      in_side,
   output logic                                       out_vld,
   output logic signed [xyc_ivk_pkg::TURN_W-1:0]      out_z,
   output logic                                       out_flip,
   output xyc_ivk_pkg::side_type                      out_side
);
   import xyc_ivk_pkg::*;

   localparam int RW = 28;                       // reduction width
   localparam int R_W = 25;                      // reduced angle, < 360 deg
   localparam logic signed [RW-1:0] FULL  = RW'(360 << FRAC_BITS);
   localparam logic signed [RW-1:0] FULL2 = RW'(2 * (360 << FRAC_BITS));
   localparam logic signed [RW-1:0] FULL3 = RW'(3 * (360 << FRAC_BITS));
   // floor(n/45) by reciprocal: exact for n < 2^25 (k = 31), n < 2^19 (k = 25)
   localparam logic [25:0] M1 = 26'd47721859;
   localparam logic [19:0] M2 = 20'd745655;
   localparam int Q1_W = 19;
   localparam int Q2_W = 13;

   logic            vld_ff [6];
   side_type        side_ff [6];

   logic signed [RW-1:0] r0_ff;
   logic [R_W-1:0]       r_ff;
   logic [R_W-1:0]       r_d_ff;
   logic [50:0]          p1_ff;
   logic [Q1_W-1:0]      q1_ff;
   logic [Q1_W-1:0]      q1_d_ff;
   logic [5:0]           r1_ff;
   logic [38:0]          p2_ff;
   logic signed [TURN_W-1:0] z_ff;
   logic                 flip_ff;

   logic signed [RW-1:0] a_ext;
   logic signed [RW-1:0] r_sel;
   logic [R_W-1:0]       rem_full;
   logic [TURN_W-1:0]    turn;
   logic signed [TURN_W-1:0] z_raw;
   logic                 need_flip;

   assign a_ext = RW'(in_angle);

   always_comb begin
      if (r0_ff >= FULL2) begin
         r_sel = r0_ff - FULL2;
      end else if (r0_ff >= FULL) begin
         r_sel = r0_ff - FULL;
      end else begin
         r_sel = r0_ff;
      end
   end

   // remainder of the reduced angle after division by 45, same stage as p1
   assign rem_full  = r_d_ff - R_W'(p1_ff[49:31] * R_W'(45));
   assign turn      = {q1_d_ff, p2_ff[37:25]};
   assign z_raw     = $signed(turn);
   assign need_flip = (z_raw > $signed(TURN_W'(1 << 30)))
                   || (z_raw < -$signed(TURN_W'(1 << 30)));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) vld_ff[i] <= 1'b0;
      end else begin
         vld_ff[0] <= in_vld;
         for (int i = 1; i < 6; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= in_side;
      for (int i = 1; i < 6; i++) side_ff[i] <= side_ff[i-1];
      // fold into [0, 3 turns)
      r0_ff   <= (a_ext < 0) ? a_ext + FULL3 : a_ext;
      r_ff    <= R_W'(r_sel);
      p1_ff   <= 51'(r_ff) * 51'(M1);
      r_d_ff  <= r_ff;
      q1_ff   <= p1_ff[49:31];
      r1_ff   <= rem_full[5:0];
      q1_d_ff <= q1_ff;
      p2_ff   <= 39'({r1_ff, 13'b0}) * 39'(M2);
      // beyond a quarter turn: rotate by half a turn, negate results later
      z_ff    <= need_flip ? {~turn[TURN_W-1], turn[TURN_W-2:0]} : z_raw;
      flip_ff <= need_flip;
   end

   assign out_vld  = vld_ff[5];
   assign out_side = side_ff[5];
   assign out_z    = z_ff;
   assign out_flip = flip_ff;

endmodule

/* rtl/core/xyc_ivk_cordic.sv */
module xyc_ivk_cordic #(
   parameter int ITER = xyc_ivk_pkg::TRIG_ITERATIONS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_vld,
   input  logic signed [xyc_ivk_pkg::TURN_W-1:0]      in_z,
   input  logic                                       in_flip,
   input  xyc_ivk_pkg::side_type                      in_side,
   output logic                                       out_vld,
   output logic signed [xyc_ivk_pkg::TRIG_W-1:0]      out_sin,
   output logic signed [xyc_ivk_pkg::TRIG_W-1:0]      out_cos,
   output xyc_ivk_pkg::side_type                      out_side
);
   import xyc_ivk_pkg::*;

   localparam int CW = 34;
   localparam int NI = (ITER < ATAN_LEN) ? ITER : ATAN_LEN;
   localparam logic signed [CW-1:0] GAIN = CW'(652032874);

   logic                     vld_ff  [NI];
   logic                     flip_ff [NI];
   side_type                 side_ff [NI];
   logic signed [CW-1:0]     x_ff    [NI];
   logic signed [CW-1:0]     y_ff    [NI];
   logic signed [TURN_W-1:0] z_ff    [NI];

   logic                     ovld_ff;
   side_type                 oside_ff;
   logic signed [TRIG_W-1:0] sin_ff;
   logic signed [TRIG_W-1:0] cos_ff;

   for (genvar k = 0; k < NI; k++) begin : g_stage
      localparam logic signed [TURN_W-1:0] ATAN = atan_turn(k);
      logic                     vi;
      logic                     fi;
      side_type                 si;
      logic signed [CW-1:0]     xi;
      logic signed [CW-1:0]     yi;
      logic signed [TURN_W-1:0] zi;

      if (k == 0) begin : g_src
         assign vi = in_vld;
         assign fi = in_flip;
         assign si = in_side;
         assign xi = GAIN;
         assign yi = '0;
         assign zi = in_z;
      end else begin : g_src
         assign vi = vld_ff[k-1];
         assign fi = flip_ff[k-1];
         assign si = side_ff[k-1];
         assign xi = x_ff[k-1];
         assign yi = y_ff[k-1];
         assign zi = z_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vi;
         end
      end

      always_ff @(posedge clock) begin
         flip_ff[k] <= fi;
         side_ff[k] <= si;
         if (zi >= 0) begin
            x_ff[k] <= xi - (yi >>> k);
            y_ff[k] <= yi + (xi >>> k);
            z_ff[k] <= zi - ATAN;
         end else begin
            x_ff[k] <= xi + (yi >>> k);
            y_ff[k] <= yi - (xi >>> k);
            z_ff[k] <= zi + ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovld_ff <= 1'b0;
      end else begin
         ovld_ff <= vld_ff[NI-1];
      end
   end

   always_ff @(posedge clock) begin
      oside_ff <= side_ff[NI-1];
      if (flip_ff[NI-1]) begin
         sin_ff <= TRIG_W'(-y_ff[NI-1]);
         cos_ff <= TRIG_W'(-x_ff[NI-1]);
      end else begin
         sin_ff <= TRIG_W'(y_ff[NI-1]);
         cos_ff <= TRIG_W'(x_ff[NI-1]);
      end
   end

   assign out_vld  = ovld_ff;
   assign out_side = oside_ff;
   assign out_sin  = sin_ff;
   assign out_cos  = cos_ff;

endmodule

/* rtl/core/xyc_ivk_terms.sv */
module xyc_ivk_terms (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_vld,
   input  logic signed [xyc_ivk_pkg::TRIG_W-1:0]      in_sin,
   input  logic signed [xyc_ivk_pkg::TRIG_W-1:0]      in_cos,
   input  xyc_ivk_pkg::side_type                      in_side,
   input  logic [xyc_ivk_pkg::ARM_W-1:0]              arm_length,
   input  logic signed [xyc_ivk_pkg::LEN_W-1:0]       tool_offset_x,
   input  logic signed [xyc_ivk_pkg::LEN_W-1:0]       tool_offset_y,
   output logic                                       out_vld,
   output logic signed [xyc_ivk_pkg::LEN_W-1:0]       out_x_rate,
   output logic signed [xyc_ivk_pkg::LEN_W-1:0]       out_y_rate,
   output logic signed [xyc_ivk_pkg::LEN_W-1:0]       out_angle_rate,
   output logic                                       out_sat
);
   import xyc_ivk_pkg::*;

   localparam int TW = 36;   // trig * length >> 30
   localparam int PW = 48;   // term * w >> F
   localparam int SW = 50;   // three-way sum

   localparam logic signed [SW-1:0] MAXV = SW'(64'sh7FFFFFFF);
   localparam logic signed [SW-1:0] MINV = -SW'(64'sh80000000);

   logic                 vld_ff [3];
   side_type             side_ff [2];

   logic signed [TW-1:0] ts_ff, tc_ff, rs_ff, rc_ff;
   logic signed [PW-1:0] mts_ff, mtc_ff, mrs_ff, mrc_ff;
   logic signed [LEN_W-1:0] jx_ff, jy_ff, ar_ff;
   logic                 sat_ff;

   logic signed [LEN_W:0]   reach;
   logic signed [63:0]      p_ts, p_tc;
   logic signed [64:0]      p_rs, p_rc;
   logic signed [63:0]      q_ts, q_tc, q_rs, q_rc;
   logic signed [SW-1:0]    jx_sum, jy_sum;
   logic                    sat_x_hi, sat_x_lo, sat_y_hi, sat_y_lo;

   assign reach = $signed({2'b00, arm_length}) + (LEN_W+1)'(tool_offset_y);
   assign p_ts  = in_sin * tool_offset_x;
   assign p_tc  = in_cos * tool_offset_x;
   assign p_rs  = in_sin * reach;
   assign p_rc  = in_cos * reach;

   assign q_ts = ts_ff * side_ff[0].w;
   assign q_tc = tc_ff * side_ff[0].w;
   assign q_rs = rs_ff * side_ff[0].w;
   assign q_rc = rc_ff * side_ff[0].w;

   assign jx_sum = SW'(side_ff[1].x_rate) + SW'(mts_ff) + SW'(mrc_ff);
   assign jy_sum = SW'(side_ff[1].y_rate) - SW'(mtc_ff) + SW'(mrs_ff);
   assign sat_x_hi = jx_sum > MAXV;
   assign sat_x_lo = jx_sum < MINV;
   assign sat_y_hi = jy_sum > MAXV;
   assign sat_y_lo = jy_sum < MINV;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) vld_ff[i] <= 1'b0;
      end else begin
         vld_ff[0] <= in_vld;
         vld_ff[1] <= vld_ff[0];
         vld_ff[2] <= vld_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= in_side;
      side_ff[1] <= side_ff[0];
      ts_ff  <= TW'(p_ts >>> 30);
      tc_ff  <= TW'(p_tc >>> 30);
      rs_ff  <= TW'(p_rs >>> 30);
      rc_ff  <= TW'(p_rc >>> 30);
      mts_ff <= PW'(q_ts >>> FRAC_BITS);
      mtc_ff <= PW'(q_tc >>> FRAC_BITS);
      mrs_ff <= PW'(q_rs >>> FRAC_BITS);
      mrc_ff <= PW'(q_rc >>> FRAC_BITS);
      jx_ff  <= sat_x_hi ? LEN_W'(MAXV) : sat_x_lo ? LEN_W'(MINV) : LEN_W'(jx_sum);
      jy_ff  <= sat_y_hi ? LEN_W'(MAXV) : sat_y_lo ? LEN_W'(MINV) : LEN_W'(jy_sum);
      ar_ff  <= side_ff[1].angle_rate;
      sat_ff <= sat_x_hi | sat_x_lo | sat_y_hi | sat_y_lo;
   end

   assign out_vld        = vld_ff[2];
   assign out_x_rate     = jx_ff;
   assign out_y_rate     = jy_ff;
   assign out_angle_rate = ar_ff;
   assign out_sat        = sat_ff;

endmodule

/* rtl/core/xyc_inverse_velocity_kinematics_unit.sv */
// Inverse velocity kinematics for an X-Y-rotation machine with a tool offset.
// One transaction is accepted every clock cycle (busy is never raised) and
// each one produces exactly one result, flagged by a one-cycle rsp_valid
// strobe. The receiver cannot stall: the result must be taken in the cycle
// it is shown. The pipeline holds one capture stage, six stages of
// modulo-360 reduction and conversion to a binary angle, one CORDIC stage
// per iteration plus an output stage, and three stages of multiply,
// multiply and sum/clamp.
// Configuration registers (index: 0 arm length, 1 tool offset x, 2 tool
// offset y, 3 tool angle) are always ready and may be written only while
// no transaction is in flight.
module xyc_inverse_velocity_kinematics_unit #(
   parameter int TRIG_ITERATIONS = xyc_ivk_pkg::TRIG_ITERATIONS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [xyc_ivk_pkg::ANG_W-1:0]    req_tcp_angle,
   input  logic signed [xyc_ivk_pkg::LEN_W-1:0]    req_tcp_x_rate,
   input  logic signed [xyc_ivk_pkg::LEN_W-1:0]    req_tcp_y_rate,
   input  logic signed [xyc_ivk_pkg::LEN_W-1:0]    req_tcp_angle_rate,
   // response
   output logic                                    rsp_valid,
   output logic signed [xyc_ivk_pkg::LEN_W-1:0]    rsp_joint_x_rate,
   output logic signed [xyc_ivk_pkg::LEN_W-1:0]    rsp_joint_y_rate,
   output logic signed [xyc_ivk_pkg::LEN_W-1:0]    rsp_joint_angle_rate,
   output logic                                    rsp_saturated,
   // configuration
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [1:0]                              csr_index,
   input  logic [xyc_ivk_pkg::LEN_W-1:0]           csr_wdata
);
   import xyc_ivk_pkg::*;

   // configuration registers
   logic [ARM_W-1:0]        arm_ff;
   logic signed [LEN_W-1:0] tox_ff;
   logic signed [LEN_W-1:0] toy_ff;
   logic signed [ANG_W-1:0] tang_ff;

   // capture stage
   logic                     vld_ff;
   logic signed [DIFF_W-1:0] a_ff;
   side_type                 side_ff;
   side_type                 side_in;
   logic signed [59:0]       w_prod;

   // angle -> cordic
   logic                     ang_vld;
   logic signed [TURN_W-1:0] ang_z;
   logic                     ang_flip;
   side_type                 ang_side;

   // cordic -> terms
   logic                     trig_vld;
   logic signed [TRIG_W-1:0] trig_sin;
   logic signed [TRIG_W-1:0] trig_cos;
   side_type                 trig_side;

   logic                     accept;

   // fully pipelined, never stalls
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_ff  <= ARM_RESET;
         tox_ff  <= '0;
         toy_ff  <= '0;
         tang_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_ARM_LENGTH:    arm_ff  <= csr_wdata[ARM_W-1:0];
            REG_TOOL_OFFSET_X: tox_ff  <= $signed(csr_wdata);
            REG_TOOL_OFFSET_Y: toy_ff  <= $signed(csr_wdata);
            REG_TOOL_ANGLE:    tang_ff <= $signed(csr_wdata[ANG_W-1:0]);
            default: ;
         endcase
      end
   end

   // angle rate to rad/s in Q(F): rate * pi/180 (Q0.32), floor shift
   assign w_prod = req_tcp_angle_rate * DEG_TO_RAD;

   always_comb begin
      side_in.x_rate     = req_tcp_x_rate;
      side_in.y_rate     = req_tcp_y_rate;
      side_in.angle_rate = req_tcp_angle_rate;
      side_in.w          = RATE_W'(w_prod >>> 32);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= DIFF_W'(req_tcp_angle) - DIFF_W'(tang_ff);
      side_ff <= side_in;
   end

   xyc_ivk_angle u_angle (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (vld_ff),
      .in_angle (a_ff),
      .in_side  (side_ff),
      .out_vld  (ang_vld),
      .out_z    (ang_z),
      .out_flip (ang_flip),
      .out_side (ang_side)
   );

   xyc_ivk_cordic #(
      .ITER (TRIG_ITERATIONS)
   ) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (ang_vld),
      .in_z     (ang_z),
      .in_flip  (ang_flip),
      .in_side  (ang_side),
      .out_vld  (trig_vld),
      .out_sin  (trig_sin),
      .out_cos  (trig_cos),
      .out_side (trig_side)
   );

   xyc_ivk_terms u_terms (
      .clock          (clock),
      .reset          (reset),
      .in_vld         (trig_vld),
      .in_sin         (trig_sin),
      .in_cos         (trig_cos),
      .in_side        (trig_side),
      .arm_length     (arm_ff),
      .tool_offset_x  (tox_ff),
      .tool_offset_y  (toy_ff),
      .out_vld        (rsp_valid),
      .out_x_rate     (rsp_joint_x_rate),
      .out_y_rate     (rsp_joint_y_rate),
      .out_angle_rate (rsp_joint_angle_rate),
      .out_sat        (rsp_saturated)
   );

endmodule

/* verif/xyc_inverse_velocity_kinematics_unit_tb.sv */
module xyc_inverse_velocity_kinematics_unit_tb;
   import xyc_ivk_pkg::*;

   // one transaction on the request side
   typedef struct {
      logic signed [ANG_W-1:0] angle;
      logic signed [LEN_W-1:0] x_rate;
      logic signed [LEN_W-1:0] y_rate;
      logic signed [LEN_W-1:0] angle_rate;
   } motion_cmd_t;

   // one joint-rate result
   typedef struct {
      logic signed [LEN_W-1:0] jx;
      logic signed [LEN_W-1:0] jy;
      logic signed [LEN_W-1:0] ja;
      logic                    sat;
   } joint_rate_t;

   localparam int CORDIC_STEPS = TRIG_ITERATIONS_DEF;
   localparam int PIPE_DELAY   = CORDIC_STEPS + 11;

   // arctangent of 2^-i, 2^32 units per turn
   localparam longint ATAN_STEP [0:23] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
      64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
      64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [ANG_W-1:0] req_tcp_angle      = '0;
   logic signed [LEN_W-1:0] req_tcp_x_rate     = '0;
   logic signed [LEN_W-1:0] req_tcp_y_rate     = '0;
   logic signed [LEN_W-1:0] req_tcp_angle_rate = '0;
   logic rsp_valid;
   logic signed [LEN_W-1:0] rsp_joint_x_rate;
   logic signed [LEN_W-1:0] rsp_joint_y_rate;
   logic signed [LEN_W-1:0] rsp_joint_angle_rate;
   logic rsp_saturated;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [LEN_W-1:0] csr_wdata = '0;

   xyc_inverse_velocity_kinematics_unit u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_tcp_angle        (req_tcp_angle),
      .req_tcp_x_rate       (req_tcp_x_rate),
      .req_tcp_y_rate       (req_tcp_y_rate),
      .req_tcp_angle_rate   (req_tcp_angle_rate),
      .rsp_valid            (rsp_valid),
      .rsp_joint_x_rate     (rsp_joint_x_rate),
      .rsp_joint_y_rate     (rsp_joint_y_rate),
      .rsp_joint_angle_rate (rsp_joint_angle_rate),
      .rsp_saturated        (rsp_saturated),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shadow copy of the geometry registers, updated on each accepted write
   longint arm_len    = longint'(ARM_RESET);
   longint tool_x     = 0;
   longint tool_y     = 0;
   longint tool_angle = 0;

   motion_cmd_t cmd_q[$];      // commands waiting to be driven
   joint_rate_t joint_q[$];    // joint rates still owed by the block
   int          errors = 0;

   // Rotate the unit vector by the tool-relative angle (degrees, Q16.16).
   // Angle is wrapped into one turn, mapped to a binary angle and folded into
   // +-90 degrees before the CORDIC, with the sign restored afterwards.
   task automatic rotate_unit(input longint deg, output longint sn, output longint cs);
      longint full_circle, r, z, x, y, nx;
      bit     flip;
      full_circle = longint'(360) << FRAC_BITS;
      r = deg % full_circle;
      if (r < 0) r += full_circle;
      z = (r << (32 - FRAC_BITS)) / 360;
      if (z >= 64'sh80000000) z -= 64'sh100000000;
      flip = 1'b0;
      if (z > 64'sh40000000) begin
         z -= 64'sh80000000;
         flip = 1'b1;
      end else if (z < -64'sh40000000) begin
         z += 64'sh80000000;
         flip = 1'b1;
      end
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= ATAN_STEP[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += ATAN_STEP[i];
         end
         x = nx;
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
   endtask

   // clamp to 32-bit signed, raising the saturation flag
   function automatic logic signed [LEN_W-1:0] clamp_rate(input longint v, inout logic sat);
      if (v > 64'sh7FFFFFFF) begin
         sat = 1'b1;
         return 32'sh7FFFFFFF;
      end
      if (v < -64'sh80000000) begin
         sat = 1'b1;
         return 32'sh80000000;
      end
      return v[LEN_W-1:0];
   endfunction

   // expected joint rates for one command under the current geometry
   task automatic joint_rates(input motion_cmd_t c, output joint_rate_t r);
      longint w, reach, sn, cs, ts, tc, rs, rc, jx, jy;
      logic   sat;
      w     = (longint'(c.angle_rate) * 74961321) >>> 32;
      reach = arm_len + tool_y;
      rotate_unit(longint'(c.angle) - tool_angle, sn, cs);
      ts = (sn * tool_x) >>> 30;
      tc = (cs * tool_x) >>> 30;
      rs = (sn * reach) >>> 30;
      rc = (cs * reach) >>> 30;
      jx = longint'(c.x_rate) + ((ts * w) >>> FRAC_BITS) + ((rc * w) >>> FRAC_BITS);
      jy = longint'(c.y_rate) - ((tc * w) >>> FRAC_BITS) + ((rs * w) >>> FRAC_BITS);
      sat  = 1'b0;
      r.jx = clamp_rate(jx, sat);
      r.jy = clamp_rate(jy, sat);
      r.ja = c.angle_rate;
      r.sat = sat;
   endtask

   // Driver: bursts of random length separated by random gaps. A command
   // stays on the bus until taken (start high, busy low at the edge).
   int burst_left = 8;
   int gap_left   = 0;
   always @(posedge clock) begin
      joint_rate_t exp_r;
      if (!reset) begin
         if (start && !busy) begin
            joint_rates(cmd_q.pop_front(), exp_r);
            joint_q.push_back(exp_r);
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (cmd_q.size() > 0) begin
            start              <= 1'b1;
            req_tcp_angle      <= cmd_q[0].angle;
            req_tcp_x_rate     <= cmd_q[0].x_rate;
            req_tcp_y_rate     <= cmd_q[0].y_rate;
            req_tcp_angle_rate <= cmd_q[0].angle_rate;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: results cannot be held off, so every strobe is checked at once
   // against the oldest outstanding transaction.
   always @(posedge clock) begin
      joint_rate_t e;
      if (!reset && rsp_valid) begin
         if (joint_q.size() == 0) begin
            $error("unexpected result: x %0d y %0d", rsp_joint_x_rate, rsp_joint_y_rate);
            errors++;
         end else begin
            e = joint_q.pop_front();
            if (rsp_joint_x_rate !== e.jx) begin
               $error("joint_x_rate exp %0d got %0d", e.jx, rsp_joint_x_rate);
               errors++;
            end
            if (rsp_joint_y_rate !== e.jy) begin
               $error("joint_y_rate exp %0d got %0d", e.jy, rsp_joint_y_rate);
               errors++;
            end
            if (rsp_joint_angle_rate !== e.ja) begin
               $error("joint_angle_rate exp %0d got %0d", e.ja, rsp_joint_angle_rate);
               errors++;
            end
            if (rsp_saturated !== e.sat) begin
               $error("saturated exp %0b got %0b", e.sat, rsp_saturated);
               errors++;
            end
         end
      end
   end

   // register write over the CSR channel; shadow updated on acceptance
   task automatic write_reg(input reg_index_type idx, input logic [LEN_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_ARM_LENGTH:    arm_len    = longint'(data[ARM_W-1:0]);
         REG_TOOL_OFFSET_X: tool_x     = longint'($signed(data));
         REG_TOOL_OFFSET_Y: tool_y     = longint'($signed(data));
         REG_TOOL_ANGLE:    tool_angle = longint'($signed(data[ANG_W-1:0]));
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic queue_cmd(input logic [31:0] ang, input logic [31:0] xr,
                            input logic [31:0] yr, input logic [31:0] ar);
      motion_cmd_t c;
      c.angle      = ang[ANG_W-1:0];
      c.x_rate     = xr;
      c.y_rate     = yr;
      c.angle_rate = ar;
      cmd_q.push_back(c);
   endtask

   // random command: mostly modest rates so most results stay unclamped,
   // with full-range values mixed in for saturation and bit coverage
   task automatic queue_random(input int n);
      logic [31:0] xr, yr, ar;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            xr = $urandom;
            yr = $urandom;
            ar = $urandom;
         end else begin
            xr = 32'($signed($urandom_range(0, 2**24)) - 2**23);
            yr = 32'($signed($urandom_range(0, 2**24)) - 2**23);
            ar = 32'($signed($urandom_range(0, 2**26)) - 2**25);
         end
         queue_cmd($urandom, xr, yr, ar);
      end
   endtask

   // hold off until the pipeline has drained completely
   task automatic drain();
      while (cmd_q.size() != 0 || joint_q.size() != 0) @(posedge clock);
      repeat (PIPE_DELAY + 5) @(posedge clock);
   endtask

   localparam logic [31:0] DEG = 32'd1 << FRAC_BITS;

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed pass at reset geometry: quadrant edges, wrap, field extremes
      queue_cmd(0, 0, 0, 0);
      queue_cmd(90 * DEG, 32'd100 << 16, 0, 32'd45 << 16);
      queue_cmd(-90 * DEG, 0, 32'd100 << 16, 32'd45 << 16);
      queue_cmd(180 * DEG, 0, 0, 32'd30 << 16);
      queue_cmd(-180 * DEG, 0, 0, -(32'd30 << 16));
      queue_cmd(360 * DEG, 0, 0, 32'd10 << 16);
      queue_cmd(359 * DEG + 32'hFFFF, 5, -5, 32'd10 << 16);
      queue_cmd(32'h01FFFFFF, 32'h7FFFFFFF, 32'h80000000, 1);
      queue_cmd(32'h02000000, 32'h80000000, 32'h7FFFFFFF, -1);
      queue_cmd(45 * DEG, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      queue_cmd(-45 * DEG, 32'h80000000, 32'h80000000, 32'h80000000);
      queue_cmd(135 * DEG, 0, 0, 32'h7FFFFFFF);
      queue_cmd(-135 * DEG, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80000000);
      queue_cmd(1, 0, 0, 32'd1000 << 16);
      drain();

      // extremes: longest arm, most negative x offset, largest y offset
      write_reg(REG_ARM_LENGTH, 32'hFFFFFFFF);
      write_reg(REG_TOOL_OFFSET_X, 32'h80000000);
      write_reg(REG_TOOL_OFFSET_Y, 32'h7FFFFFFF);
      write_reg(REG_TOOL_ANGLE, 32'd360 * DEG);
      queue_cmd(30 * DEG, 0, 0, 32'd90 << 16);
      queue_cmd(-60 * DEG, 32'd500 << 16, 0, -(32'd90 << 16));
      queue_random(100);
      drain();

      // negative effective arm: y offset far below minus the arm length
      write_reg(REG_ARM_LENGTH, 0);
      write_reg(REG_TOOL_OFFSET_X, 32'h7FFFFFFF);
      write_reg(REG_TOOL_OFFSET_Y, 32'h80000000);
      write_reg(REG_TOOL_ANGLE, -32'sd360 * $signed(DEG));
      queue_cmd(0, 0, 0, 32'd20 << 16);
      queue_random(100);
      drain();

      // several random geometries, moderate and full-range
      for (int p = 0; p < 4; p++) begin
         write_reg(REG_ARM_LENGTH, (p[0]) ? $urandom : $urandom_range(0, 2000 << 16));
         write_reg(REG_TOOL_OFFSET_X,
                   (p[1]) ? $urandom : 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16)));
         write_reg(REG_TOOL_OFFSET_Y, $urandom);
         write_reg(REG_TOOL_ANGLE, $urandom);
         queue_random(100);
         drain();
      end

      // back to the power-on geometry for a final burst
      write_reg(REG_ARM_LENGTH, 32'(ARM_RESET));
      write_reg(REG_TOOL_OFFSET_X, 0);
      write_reg(REG_TOOL_OFFSET_Y, 0);
      write_reg(REG_TOOL_ANGLE, 0);
      queue_random(80);
      drain();

      if (errors == 0) begin
         $display("xyc_inverse_velocity_kinematics_unit_tb OK");
      end else begin
         $display("xyc_inverse_velocity_kinematics_unit_tb NOT OK");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("xyc_inverse_velocity_kinematics_unit_tb NOT OK");
      $finish;
   end

endmodule
